[design/fdm_pkg.sv]
// Shared constants, item types, sequencer types and the sine table for the flanger core.
`default_nettype none
package fdm_pkg;

  localparam int BUFFER_DEPTH = 4096;
  localparam int SINE_ENTRIES = 1024;
  localparam int FRAC_BITS    = 8;

  localparam int SAMPLE_W  = 16;
  localparam int BASE_W    = 20;
  localparam int DEPTH_W   = 20;
  localparam int STEP_W    = 24;
  localparam int PHASE_W   = 24;
  localparam int CFG_LEN_W = 13;
  localparam int CFG_LEN_RESET = 4096;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam int ADDR_W    = $clog2(BUFFER_DEPTH);
  localparam int LEN_W     = ADDR_W + 1;
  localparam int SINE_AW   = $clog2(SINE_ENTRIES);
  localparam int POS_W     = ADDR_W + FRAC_BITS;
  localparam int D_W       = ((POS_W > BASE_W) ? POS_W : BASE_W) + 2;
  localparam int SINE_FRAC = SAMPLE_W - 1;

  localparam int MUL_A_W   = DEPTH_W + 1;
  localparam int MUL_B_W   = SAMPLE_W + 1;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int SUM_W     = SAMPLE_W + FRAC_BITS + 3;

  typedef enum logic [1:0] {
    REG_BASE_DELAY,
    REG_DEPTH_AMOUNT,
    REG_PHASE_STEP,
    REG_BUFFER_LEN
  } fdm_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       last_sample;
  } fdm_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;
  } fdm_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SINE,
    ST_ADDR,
    ST_RD1,
    ST_RD2,
    ST_MIX,
    ST_DONE
  } fdm_state_t;

  typedef struct packed {
    logic busy;
    logic take;
    logic mul_en;
    logic mul_mix;
    logic addr_en;
    logic rd_second;
    logic s1_en;
    logic wr_en;
    logic wr_clear;
    logic finish;
  } fdm_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic last;
  } fdm_stat_t;

  typedef logic [SINE_ENTRIES-1:0][SAMPLE_W-1:0] sine_rom_t;

  // Q1.15 sine from a Q30 Taylor series on the folded quarter wave.
  function automatic logic [SAMPLE_W-1:0] sine_entry(input int unsigned k);
    logic [63:0] turn;
    logic [63:0] part;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] mag;
    logic [1:0]  quad;
    turn = (64'(k) << 32) / 64'(SINE_ENTRIES);
    quad = turn[31:30];
    part = turn & 64'h3FFF_FFFF;
    if (quad[0]) begin
      part = 64'h4000_0000 - part;
    end
    x    = (part * 64'd1686629713) >> 30;
    x2   = (x * x) >> 30;
    pos  = x;
    term = ((x * x2) >> 30) / 64'd6;
    neg  = term;
    term = ((term * x2) >> 30) / 64'd20;
    pos  = pos + term;
    term = ((term * x2) >> 30) / 64'd42;
    neg  = neg + term;
    term = ((term * x2) >> 30) / 64'd72;
    pos  = pos + term;
    term = ((term * x2) >> 30) / 64'd110;
    neg  = neg + term;
    mag  = (pos > neg) ? (pos - neg) : 64'd0;
    mag  = (mag * 64'd32767 + 64'h2000_0000) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return quad[1] ? (SAMPLE_W'(0) - SAMPLE_W'(mag)) : SAMPLE_W'(mag);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage
`default_nettype wire

[design/flanger_delay_mix_core.sv]
// Top level of the flanger core: configuration registers, datapath and output register.
`default_nettype none
// A sine LFO sweeps a fractional delay around base_delay by up to depth_amount (both in
// samples with 8 fraction bits); the core reads two neighboring delay entries, interpolates
// between them and returns the truncated half sum of the input and the delayed sample.
// An item is accepted in the idle state, then steps through the sine, address, two read,
// mix and done states; no new item is taken before the last is through, and the done
// state waits while the result side stalls. The single multiplier, used once for the LFO
// swing and once for the interpolation, and the single-port delay memory (two reads and
// one write per item) set this order. After reset and after every item marked as last, a
// clearing pass zeroes all 4096 delay entries, one per cycle, taking no item; configuration
// writes are taken at any time but should be made only while the core is idle.
module flanger_delay_mix_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  fdm_pkg::fdm_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output fdm_pkg::fdm_out_t           out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fdm_pkg::PADDR_W-1:0] paddr,
  input  logic [fdm_pkg::PDATA_W-1:0] pwdata,
  output logic [fdm_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import fdm_pkg::*;

  // Configuration registers.
  logic [BASE_W-1:0]    base_delay;
  logic [DEPTH_W-1:0]   depth_amount;
  logic [STEP_W-1:0]    phase_step;
  logic [CFG_LEN_W-1:0] buffer_len;
  fdm_reg_t             cfg_idx;

  // Item state.
  logic [ADDR_W-1:0]          write_pos;
  logic [ADDR_W-1:0]          write_pos_next;
  logic [PHASE_W-1:0]         lfo_phase;
  logic signed [SAMPLE_W-1:0] x_r;
  logic                       last_r;
  logic signed [SAMPLE_W-1:0] sn_r;
  logic signed [SAMPLE_W-1:0] s1_r;
  logic [ADDR_W-1:0]          i1_r;
  logic [ADDR_W-1:0]          i2_r;
  logic [FRAC_BITS-1:0]       f_r;

  fdm_ctrl_t         ctrl;
  fdm_stat_t         stat;
  logic [ADDR_W-1:0] clr_addr;

  logic [LEN_W-1:0]  len_eff;
  logic [ADDR_W-1:0] wp_eff;
  logic [LEN_W-1:0]  wp_inc;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [SAMPLE_W:0]  diff;

  logic signed [D_W-1:0]     d_sh;
  logic signed [D_W-1:0]     d_val;
  logic [POS_W-1:0]          dmax;
  logic [POS_W-1:0]          dcl;
  logic signed [POS_W+1:0]   rp_s;
  logic signed [POS_W+1:0]   rp_a;
  logic [POS_W-1:0]          rp;
  logic [LEN_W-1:0]          i1_inc;
  logic [ADDR_W-1:0]         i2;

  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   rnd;
  logic signed [SUM_W-1:0]   sum_b;
  logic signed [SUM_W-1:0]   res_w;

  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_addr;
  logic signed [SAMPLE_W-1:0] mem_wdata;
  logic signed [SAMPLE_W-1:0] mem_rdata;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_idx = fdm_reg_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay   <= '0;
      depth_amount <= '0;
      phase_step   <= '0;
      buffer_len   <= CFG_LEN_W'(CFG_LEN_RESET);
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        REG_BASE_DELAY:   base_delay   <= pwdata[BASE_W-1:0];
        REG_DEPTH_AMOUNT: depth_amount <= pwdata[DEPTH_W-1:0];
        REG_PHASE_STEP:   phase_step   <= pwdata[STEP_W-1:0];
        REG_BUFFER_LEN:   buffer_len   <= pwdata[CFG_LEN_W-1:0];
        default:          base_delay   <= base_delay;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BASE_DELAY:   prdata = PDATA_W'(base_delay);
      REG_DEPTH_AMOUNT: prdata = PDATA_W'(depth_amount);
      REG_PHASE_STEP:   prdata = PDATA_W'(phase_step);
      REG_BUFFER_LEN:   prdata = PDATA_W'(buffer_len);
      default:          prdata = '0;
    endcase
  end

  // Effective length and write position.
  always_comb begin
    if (buffer_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(buffer_len) > 32'(BUFFER_DEPTH)) begin
      len_eff = LEN_W'(BUFFER_DEPTH);
    end else begin
      len_eff = LEN_W'(buffer_len);
    end
  end

  assign wp_eff = (LEN_W'(write_pos) >= len_eff) ? '0 : write_pos;
  assign wp_inc = LEN_W'(wp_eff) + 1'b1;

  always_comb begin
    if (last_r || (wp_inc >= len_eff)) begin
      write_pos_next = '0;
    end else begin
      write_pos_next = ADDR_W'(wp_inc);
    end
  end

  // Sequencer.
  assign stat.in_valid = in_valid;
  assign stat.out_free = !out_valid || !out_stall;
  assign stat.last     = last_r;
  assign in_stall      = ctrl.busy;

  fdm_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .ctrl     (ctrl),
    .clr_addr (clr_addr)
  );

  // Shared multiplier: LFO swing first, then the interpolation step.
  assign diff = {mem_rdata[SAMPLE_W-1], mem_rdata} - {s1_r[SAMPLE_W-1], s1_r};

  always_comb begin
    if (ctrl.mul_mix) begin
      mul_a = MUL_A_W'(diff);
      mul_b = MUL_B_W'({1'b0, f_r});
    end else begin
      mul_a = MUL_A_W'({1'b0, depth_amount});
      mul_b = MUL_B_W'(sn_r);
    end
  end

  fdm_mul u_mul (
    .clk (clk),
    .en  (ctrl.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Delay and read position. The arithmetic shift rounds the swing toward minus infinity.
  always_comb begin
    d_sh  = D_W'(signed'(mul_p[MUL_P_W-1:SINE_FRAC]));
    d_val = signed'(D_W'(base_delay)) + d_sh;
    dmax  = {ADDR_W'(len_eff - 1'b1), {FRAC_BITS{1'b0}}};
    if (d_val[D_W-1]) begin
      dcl = '0;
    end else if (d_val > signed'(D_W'(dmax))) begin
      dcl = dmax;
    end else begin
      dcl = POS_W'(d_val);
    end
    rp_s = signed'({2'b00, wp_eff, {FRAC_BITS{1'b0}}}) - signed'({2'b00, dcl});
    if (rp_s[POS_W+1]) begin
      rp_a = rp_s + signed'({1'b0, len_eff, {FRAC_BITS{1'b0}}});
    end else begin
      rp_a = rp_s;
    end
    rp     = rp_a[POS_W-1:0];
    i1_inc = LEN_W'(rp[POS_W-1:FRAC_BITS]) + 1'b1;
    i2     = (i1_inc >= len_eff) ? '0 : ADDR_W'(i1_inc);
  end

  // Mix: (x + s1) * 2^F + (s2 - s1) * f, halved and truncated toward zero.
  always_comb begin
    sum   = ((SUM_W'(x_r) + SUM_W'(s1_r)) <<< FRAC_BITS) + SUM_W'(mul_p);
    rnd   = sum[SUM_W-1] ? SUM_W'((1 << (FRAC_BITS + 1)) - 1) : '0;
    sum_b = sum + rnd;
    res_w = sum_b >>> (FRAC_BITS + 1);
  end

  // Delay memory: reads of both taps, then the new sample, or zeros while clearing.
  always_comb begin
    mem_we    = ctrl.wr_en || ctrl.wr_clear;
    mem_wdata = ctrl.wr_clear ? '0 : x_r;
    if (ctrl.wr_clear) begin
      mem_addr = clr_addr;
    end else if (ctrl.wr_en) begin
      mem_addr = wp_eff;
    end else if (ctrl.rd_second) begin
      mem_addr = i2_r;
    end else begin
      mem_addr = i1_r;
    end
  end

  fdm_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      x_r    <= in_data.sample_in;
      last_r <= in_data.last_sample;
      sn_r   <= SINE_ROM[lfo_phase[PHASE_W-1 -: SINE_AW]];
    end
    if (ctrl.addr_en) begin
      i1_r <= rp[POS_W-1:FRAC_BITS];
      i2_r <= i2;
      f_r  <= rp[FRAC_BITS-1:0];
    end
    if (ctrl.s1_en) begin
      s1_r <= mem_rdata;
    end
    if (ctrl.finish) begin
      out_data.sample_out <= res_w[SAMPLE_W-1:0];
      out_data.last_out   <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos <= '0;
      lfo_phase <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.finish) begin
        write_pos <= write_pos_next;
        lfo_phase <= last_r ? '0 : lfo_phase + PHASE_W'(phase_step);
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // An item taken while the output is empty shows its result after the sine, address, read, mix and done states.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !out_valid) |-> ##7 out_valid)
    else $error("result did not arrive on schedule");

  // Both taps lie inside the active length.
  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.s1_en |-> ((LEN_W'(i1_r) < len_eff) && (LEN_W'(i2_r) < len_eff)))
    else $error("delay tap outside active length");

  // The two taps are distinct neighbors unless the length is one entry.
  a_tap_pair: assert property (@(posedge clk) disable iff (rst)
    (ctrl.s1_en && (len_eff != LEN_W'(1))) |-> (i1_r != i2_r))
    else $error("delay taps collide");
`endif

endmodule
`default_nettype wire

[design/fdm_mul.sv]
// Shared signed multiplier with a registered product.
`default_nettype none
module fdm_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [fdm_pkg::MUL_A_W-1:0]  a,
  input  logic signed [fdm_pkg::MUL_B_W-1:0]  b,
  output logic signed [fdm_pkg::MUL_P_W-1:0]  p
);
  import fdm_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= MUL_P_W'(a) * MUL_P_W'(b);
    end
  end

endmodule
`default_nettype wire

[design/fdm_store.sv]
// Single-port delay sample memory with registered read data.
`default_nettype none
module fdm_store (
  input  logic                                clk,
  input  logic                                we,
  input  logic [fdm_pkg::ADDR_W-1:0]          addr,
  input  logic signed [fdm_pkg::SAMPLE_W-1:0] wdata,
  output logic signed [fdm_pkg::SAMPLE_W-1:0] rdata
);
  import fdm_pkg::*;

  logic [SAMPLE_W-1:0] mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

[design/fdm_seq.sv]
// Sequencer that steps one item through the shared multiplier and the delay memory.
`default_nettype none
module fdm_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  fdm_pkg::fdm_stat_t         stat,
  output fdm_pkg::fdm_ctrl_t         ctrl,
  output logic [fdm_pkg::ADDR_W-1:0] clr_addr
);
  import fdm_pkg::*;

  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(BUFFER_DEPTH - 1);

  fdm_state_t        state;
  fdm_state_t        state_next;
  logic [ADDR_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= (clr_cnt == CLR_LAST) ? '0 : clr_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == CLR_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (stat.in_valid) begin
          state_next = ST_SINE;
        end
      end
      ST_SINE: state_next = ST_ADDR;
      ST_ADDR: state_next = ST_RD1;
      ST_RD1:  state_next = ST_RD2;
      ST_RD2:  state_next = ST_MIX;
      ST_MIX:  state_next = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) begin
          state_next = stat.last ? ST_CLEAR : ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    ctrl.busy = (state != ST_IDLE);
    case (state)
      ST_CLEAR: ctrl.wr_clear = 1'b1;
      ST_IDLE:  ctrl.take     = stat.in_valid;
      ST_SINE:  ctrl.mul_en   = 1'b1;
      ST_ADDR:  ctrl.addr_en  = 1'b1;
      ST_RD1:   ctrl.busy     = 1'b1;
      ST_RD2: begin
        ctrl.rd_second = 1'b1;
        ctrl.s1_en     = 1'b1;
      end
      ST_MIX: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_mix = 1'b1;
        ctrl.wr_en   = 1'b1;
      end
      ST_DONE:  ctrl.finish   = stat.out_free;
      default:  ctrl.busy     = 1'b1;
    endcase
  end

  assign clr_addr = clr_cnt;

endmodule
`default_nettype wire
